### design/epoch_seconds_to_civil_datetime_macros.svh
// Assertion macros for the epoch seconds to civil date and time converter.
// Included by the top level; the macros expect clk and rst in scope.
`ifndef EPOCH_SECONDS_TO_CIVIL_DATETIME_MACROS_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATETIME_MACROS_SVH

// The condition implies the expression in the same cycle.
`define ES2CD_ASSERT_SAME(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The condition implies the expression in the next cycle.
`define ES2CD_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### design/es2cd_pkg.sv
// Shared widths and constants for the epoch seconds to civil date converter.
// Used by es2cd_date and epoch_seconds_to_civil_datetime; no dependencies.
`default_nettype none

package es2cd_pkg;

  // Field widths.
  localparam int IN_W     = 40;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // Internal value widths.
  localparam int XHI_W  = 31;   // input seconds above the low seven bits
  localparam int LO_W   = 7;
  localparam int DCNT_W = 22;   // whole days since the epoch
  localparam int SOD_W  = 17;   // seconds of the day
  localparam int MT_W   = 11;   // minutes of the day
  localparam int ERA_W  = 5;
  localparam int DOE_W  = 18;   // day of era
  localparam int YOE_W  = 9;    // year of era
  localparam int DOY_W  = 9;    // day of March-based year
  localparam int MP_W   = 4;    // March-based month
  localparam int T_W    = 11;
  localparam int Q36_W  = 3;
  localparam int Q1460_W = 7;
  localparam int C100_W = 2;

  // Pipeline length: input register through output register.
  localparam int DEPTH = 12;

  localparam logic [37:0] SEC_MAX = 38'd253402300799;

  // A day is 675 * 128 seconds; the factor of 128 is split off as bits.
  localparam logic [9:0]  DAY_ODD = 10'd675;

  // Division by a constant d of a value below 2^w: multiply by ceil(2^s / d)
  // with s = w + ceil(log2 d), then shift right by s. This is exact.
  localparam int          DAY_S   = 41;
  localparam logic [31:0] DAY_M   = 32'(((64'd1 << DAY_S) + 64'd674) / 64'd675);
  localparam int          P1_W    = XHI_W + 32;

  localparam logic [DCNT_W-1:0] Z_ADD    = 22'd719468;
  localparam logic [DOE_W-1:0]  ERA_DAYS = 18'd146097;
  localparam int                ERA_S    = 40;
  localparam logic [22:0]       ERA_M    =
    23'(((64'd1 << ERA_S) + 64'd146096) / 64'd146097);
  localparam int                PE_W     = DCNT_W + 23;

  localparam logic [5:0]  SEC_PER_MIN = 6'd60;
  localparam int          SEC60_S = 23;
  localparam logic [17:0] SEC60_M = 18'(((64'd1 << SEC60_S) + 64'd59) / 64'd60);
  localparam int          PS_W    = SOD_W + 18;
  localparam int          MIN60_S = 17;
  localparam logic [11:0] MIN60_M = 12'(((64'd1 << MIN60_S) + 64'd59) / 64'd60);
  localparam int          PH_W    = MT_W + 12;

  localparam int          Y1460_S = 29;
  localparam logic [18:0] Y1460_M = 19'(((64'd1 << Y1460_S) + 64'd1459) / 64'd1460);
  localparam int          Y365_S  = 27;
  localparam logic [18:0] Y365_M  = 19'(((64'd1 << Y365_S) + 64'd364) / 64'd365);
  localparam int          PY_W    = DOE_W + 19;

  localparam logic [DOE_W-1:0] CENT_1 = 18'd36524;
  localparam logic [DOE_W-1:0] CENT_2 = 18'd73048;
  localparam logic [DOE_W-1:0] CENT_3 = 18'd109572;
  localparam logic [DOE_W-1:0] CENT_4 = 18'd146096;

  localparam logic [DOE_W-1:0] DAYS_YEAR = 18'd365;
  localparam logic [YOE_W-1:0] YOE_C1    = 9'd100;
  localparam logic [YOE_W-1:0] YOE_C2    = 9'd200;
  localparam logic [YOE_W-1:0] YOE_C3    = 9'd300;
  localparam logic [YEAR_W-1:0] ERA_YEARS = 14'd400;

  localparam int          MP_S   = 19;
  localparam logic [11:0] MP_M   = 12'(((64'd1 << MP_S) + 64'd152) / 64'd153);
  localparam int          PM_W   = T_W + 12;

  localparam logic [MP_W-1:0] MP_JAN = 4'd10;

  // First day (0-based) of each March-based month within the year.
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/es2cd_date.sv
// Day count to proleptic Gregorian year, month and day, nine register stages.
// Depends on es2cd_pkg for widths, reciprocal constants and the month table.
`default_nettype none

module es2cd_date (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          ok,
  input  logic [es2cd_pkg::DCNT_W-1:0]  dcount,
  output logic [es2cd_pkg::YEAR_W-1:0]  year,
  output logic [es2cd_pkg::MONTH_W-1:0] month,
  output logic [es2cd_pkg::DAY_W-1:0]   day
);
  import es2cd_pkg::*;

  logic               ok3, ok4, ok5, ok6, ok7, ok8, ok9, ok10;
  logic [DCNT_W-1:0]  z3, z4;
  logic [PE_W-1:0]    pe4;
  logic [ERA_W-1:0]   era5, era6, era7, era8, era9, era10;
  logic [DOE_W-1:0]   doe5, doe6, doe7, doe8;
  logic [PY_W-1:0]    p1460_6, p365_8;
  logic [Q36_W-1:0]   q36_6;
  logic               q146_6;
  logic [DOE_W-1:0]   n7;
  logic [YOE_W-1:0]   yoe9, yoe10;
  logic [DOY_W-1:0]   doy9, doy10;
  logic [PM_W-1:0]    pm10;

  logic [ERA_W-1:0]   era_c;
  logic [DOE_W-1:0]   doe_c;
  logic [YOE_W-1:0]   yoe_c;
  logic [C100_W-1:0]  c100;
  logic [DOE_W-1:0]   ystart;
  logic [DOE_W-1:0]   doy_full;
  logic [T_W-1:0]     t_c;
  logic [MP_W-1:0]    mp_c;
  logic [MONTH_W-1:0] mo_c;
  logic [YEAR_W-1:0]  yr_c;
  logic [DOY_W-1:0]   day_full;

  assign era_c = pe4[ERA_S +: ERA_W];
  assign doe_c = DOE_W'(z4 - DCNT_W'(era_c) * DCNT_W'(ERA_DAYS));

  // Year of era: (doe - doe/1460 + doe/36524 - doe/146096) / 365.
  assign yoe_c = p365_8[Y365_S +: YOE_W];
  assign c100  = C100_W'(yoe_c >= YOE_C1) + C100_W'(yoe_c >= YOE_C2)
               + C100_W'(yoe_c >= YOE_C3);
  assign ystart = DOE_W'(yoe_c) * DAYS_YEAR + DOE_W'(yoe_c[YOE_W-1:2]) - DOE_W'(c100);
  assign doy_full = doe8 - ystart;

  assign t_c = T_W'(doy9) * T_W'(5) + T_W'(2);

  assign mp_c = pm10[MP_S +: MP_W];
  assign mo_c = (mp_c < MP_JAN) ? MONTH_W'(mp_c + MP_W'(3)) : MONTH_W'(mp_c - MP_W'(9));
  assign yr_c = YEAR_W'(yoe10) + YEAR_W'(era10) * ERA_YEARS
              + YEAR_W'(mo_c <= MONTH_W'(2));
  assign day_full = doy10 - month_start(mp_c) + DOY_W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      z3      <= dcount + Z_ADD;
      ok3     <= ok;

      pe4     <= PE_W'(z3) * PE_W'(ERA_M);
      z4      <= z3;
      ok4     <= ok3;

      era5    <= era_c;
      doe5    <= doe_c;
      ok5     <= ok4;

      p1460_6 <= PY_W'(doe5) * PY_W'(Y1460_M);
      q36_6   <= Q36_W'(doe5 >= CENT_1) + Q36_W'(doe5 >= CENT_2)
                 + Q36_W'(doe5 >= CENT_3) + Q36_W'(doe5 >= CENT_4);
      q146_6  <= (doe5 == CENT_4);
      doe6    <= doe5;
      era6    <= era5;
      ok6     <= ok5;

      n7      <= doe6 - DOE_W'(p1460_6[Y1460_S +: Q1460_W]) + DOE_W'(q36_6)
                 - DOE_W'(q146_6);
      doe7    <= doe6;
      era7    <= era6;
      ok7     <= ok6;

      p365_8  <= PY_W'(n7) * PY_W'(Y365_M);
      doe8    <= doe7;
      era8    <= era7;
      ok8     <= ok7;

      yoe9    <= yoe_c;
      doy9    <= doy_full[DOY_W-1:0];
      era9    <= era8;
      ok9     <= ok8;

      pm10    <= PM_W'(t_c) * PM_W'(MP_M);
      yoe10   <= yoe9;
      doy10   <= doy9;
      era10   <= era9;
      ok10    <= ok9;

      // Out-of-range items leave with all date fields cleared.
      year    <= ok10 ? yr_c : '0;
      month   <= ok10 ? mo_c : '0;
      day     <= ok10 ? day_full[DAY_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

### design/epoch_seconds_to_civil_datetime.sv
// Top level: epoch seconds to proleptic Gregorian date and time of day.
// Depends on es2cd_pkg, es2cd_date and the assertion macro header.
//
//   channel  valid        stall        payload
//   input    epoch_valid  epoch_stall  epoch_second
//   output   date_valid   date_stall   valid_res year month day hour minute second
//
// One item enters per cycle unless the output stalls; each result appears in the
// last of twelve register stages of reciprocal multiplies.
// Reset clears only the per-stage valid bits; there is no clearing pass.
// An output stall holds every stage while a finished result waits; epoch_stall
// rises only then, so one item per cycle flows whenever date_stall is low.
`default_nettype none
`include "epoch_seconds_to_civil_datetime_macros.svh"

module epoch_seconds_to_civil_datetime (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              epoch_valid,
  output logic                              epoch_stall,
  input  logic signed [es2cd_pkg::IN_W-1:0] epoch_second,
  output logic                              date_valid,
  input  logic                              date_stall,
  output logic                              valid_res,
  output logic [es2cd_pkg::YEAR_W-1:0]      year,
  output logic [es2cd_pkg::MONTH_W-1:0]     month,
  output logic [es2cd_pkg::DAY_W-1:0]       day,
  output logic [es2cd_pkg::HOUR_W-1:0]      hour,
  output logic [es2cd_pkg::MINUTE_W-1:0]    minute,
  output logic [es2cd_pkg::SECOND_W-1:0]    second
);
  import es2cd_pkg::*;

  localparam logic [YEAR_W-1:0] YEAR_LO = 14'd1970;
  localparam logic [YEAR_W-1:0] YEAR_HI = 14'd9999;

  logic [DEPTH-1:0] vld;
  logic             en;

  logic             ok0, ok1, ok2, ok3, ok4, ok5, ok6;
  logic             ok_d [7:DEPTH-2];
  logic [XHI_W-1:0] xhi0, xhi1;
  logic [LO_W-1:0]  lo0, lo1;
  logic [P1_W-1:0]  p1;
  logic [DCNT_W-1:0] dcount2;
  logic [SOD_W-1:0] sod2, sod3;
  logic [PS_W-1:0]  ps3;
  logic [MT_W-1:0]  mt4, mt5;
  logic [PH_W-1:0]  ph5;
  logic [SECOND_W-1:0] sec4, sec5, sec6;
  logic [HOUR_W-1:0]   hour6;
  logic [MINUTE_W-1:0] minute6;
  logic [HOUR_W-1:0]   hour_d   [7:DEPTH-2];
  logic [MINUTE_W-1:0] minute_d [7:DEPTH-2];
  logic [SECOND_W-1:0] second_d [7:DEPTH-2];

  logic [DCNT_W-1:0] dq;
  logic [XHI_W-1:0]  rem_full;
  logic [MT_W-1:0]   mt_c;
  logic [SOD_W-1:0]  sec_full;
  logic [HOUR_W-1:0] hr_c;
  logic [MT_W-1:0]   min_full;
  logic              fields_zero;
  logic              date_ok;

  // The whole pipeline advances unless a finished result is held.
  assign en          = !(vld[DEPTH-1] && date_stall);
  assign epoch_stall = !en;
  assign date_valid  = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], epoch_valid};
    end
  end

  // Seconds to whole days and seconds of the day.
  assign dq       = p1[DAY_S +: DCNT_W];
  assign rem_full = xhi1 - XHI_W'(dq) * XHI_W'(DAY_ODD);

  // Seconds of the day to minutes, then minutes to hours.
  assign mt_c     = ps3[SEC60_S +: MT_W];
  assign sec_full = sod3 - SOD_W'(mt_c) * SOD_W'(SEC_PER_MIN);
  assign hr_c     = ph5[MIN60_S +: HOUR_W];
  assign min_full = mt5 - MT_W'(hr_c) * MT_W'(SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (en) begin
      ok0     <= (epoch_second[IN_W-1:IN_W-2] == 2'b00)
                 && (epoch_second[IN_W-3:0] <= SEC_MAX);
      xhi0    <= epoch_second[LO_W +: XHI_W];
      lo0     <= epoch_second[LO_W-1:0];

      p1      <= P1_W'(xhi0) * P1_W'(DAY_M);
      xhi1    <= xhi0;
      lo1     <= lo0;
      ok1     <= ok0;

      dcount2 <= dq;
      sod2    <= {rem_full[9:0], lo1};
      ok2     <= ok1;

      ps3     <= PS_W'(sod2) * PS_W'(SEC60_M);
      sod3    <= sod2;
      ok3     <= ok2;

      mt4     <= mt_c;
      sec4    <= sec_full[SECOND_W-1:0];
      ok4     <= ok3;

      ph5     <= PH_W'(mt4) * PH_W'(MIN60_M);
      mt5     <= mt4;
      sec5    <= sec4;
      ok5     <= ok4;

      hour6   <= hr_c;
      minute6 <= min_full[MINUTE_W-1:0];
      sec6    <= sec5;
      ok6     <= ok5;

      ok_d[7]     <= ok6;
      hour_d[7]   <= hour6;
      minute_d[7] <= minute6;
      second_d[7] <= sec6;
      for (int i = 8; i <= DEPTH - 2; i++) begin
        ok_d[i]     <= ok_d[i-1];
        hour_d[i]   <= hour_d[i-1];
        minute_d[i] <= minute_d[i-1];
        second_d[i] <= second_d[i-1];
      end

      valid_res <= ok_d[DEPTH-2];
      hour      <= ok_d[DEPTH-2] ? hour_d[DEPTH-2]   : '0;
      minute    <= ok_d[DEPTH-2] ? minute_d[DEPTH-2] : '0;
      second    <= ok_d[DEPTH-2] ? second_d[DEPTH-2] : '0;
    end
  end

  es2cd_date u_date (
    .clk    (clk),
    .en     (en),
    .ok     (ok2),
    .dcount (dcount2),
    .year   (year),
    .month  (month),
    .day    (day)
  );

  assign fields_zero = (year == '0) && (month == '0) && (day == '0)
                    && (hour == '0) && (minute == '0) && (second == '0);
  assign date_ok = (year >= YEAR_LO) && (year <= YEAR_HI)
                && (month >= MONTH_W'(1)) && (month <= MONTH_W'(12))
                && (day >= DAY_W'(1))
                && (hour <= HOUR_W'(23)) && (minute <= MINUTE_W'(59))
                && (second <= SECOND_W'(59));

  `ES2CD_ASSERT_SAME(a_invalid_zero, date_valid && !valid_res, fields_zero, "invalid item has fields")
  `ES2CD_ASSERT_SAME(a_date_range, date_valid && valid_res, date_ok, "result out of range")
  `ES2CD_ASSERT_NEXT(a_stall_holds, date_valid && date_stall, vld == $past(vld), "stall moved pipe")

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for epoch_seconds_to_civil_datetime: directed timestamps, then
// random ones, checked against listed dates or a predictor under idling and backpressure.
// Depends on es2cd_pkg and the converter RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import es2cd_pkg::*;

  localparam longint LAST_SECOND  = 64'sd253402300799;
  localparam longint LAST_DAY     = 64'sd2932896;
  localparam int     RANDOM_ITEMS = 930;
  localparam int     BLOCK_ITEMS  = 100;
  localparam int     SQUEEZE_AT   = 400;
  localparam int     HOLD_CYCLES  = 200;
  localparam int     IDLE_LIMIT   = 2000;
  localparam int     MAX_REPORTS  = 10;

  typedef struct packed {
    logic                valid_res;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } date_t;

  typedef struct {
    logic signed [IN_W-1:0] sec;
    date_t                  want;
  } conversion_t;

  typedef struct {
    logic signed [IN_W-1:0] sec;
    bit                     typed;
    date_t                  want;
  } stim_row_t;

  localparam date_t NO_DATE = '0;

  logic clk;
  logic rst;
  logic epoch_valid;
  logic epoch_stall;
  logic signed [IN_W-1:0] epoch_second;
  logic date_valid;
  logic date_stall;
  logic valid_res;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;

  // Expected date of the item currently offered on the input.
  date_t epoch_want;

  conversion_t pending_dates[$];
  stim_row_t   dir_rows[$];

  int  mismatches  = 0;
  int  unexpected  = 0;
  int  n_taken     = 0;
  int  n_in_range  = 0;
  int  n_checked   = 0;
  int  held_inputs = 0;
  int  idle_cycles = 0;
  bit  quiet_tx    = 1'b0;
  bit  quiet_rx    = 1'b0;
  bit  squeeze_req = 1'b0;

  epoch_seconds_to_civil_datetime u_dut (
    .clk          (clk),
    .rst          (rst),
    .epoch_valid  (epoch_valid),
    .epoch_stall  (epoch_stall),
    .epoch_second (epoch_second),
    .date_valid   (date_valid),
    .date_stall   (date_stall),
    .valid_res    (valid_res),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Era-based conversion: days since 0000-03-01, split into 400-year eras,
  // then year of era, day of a year that starts in March, and month.
  function automatic date_t civil_from_epoch(logic signed [IN_W-1:0] sec);
    longint s, days, sod, z, era, doe, yoe, doy, mp, mo, yr;
    date_t  r;
    r = NO_DATE;
    s = sec;
    if (s < 0 || s > LAST_SECOND) return r;
    days = s / 86400;
    sod  = s % 86400;
    z    = days + 719468;
    era  = z / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    mo   = (mp < 10) ? mp + 3 : mp - 9;
    yr   = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
    r.valid_res = 1'b1;
    r.year   = yr[YEAR_W-1:0];
    r.month  = mo[MONTH_W-1:0];
    r.day    = 5'(doy - (153 * mp + 2) / 5 + 1);
    r.hour   = 5'(sod / 3600);
    r.minute = 6'((sod % 3600) / 60);
    r.second = 6'(sod % 60);
    return r;
  endfunction

  function automatic date_t civil(int y, int mo, int d, int h, int mi, int s);
    date_t r;
    r.valid_res = 1'b1;
    r.year   = y[YEAR_W-1:0];
    r.month  = mo[MONTH_W-1:0];
    r.day    = d[DAY_W-1:0];
    r.hour   = h[HOUR_W-1:0];
    r.minute = mi[MINUTE_W-1:0];
    r.second = s[SECOND_W-1:0];
    return r;
  endfunction

  function automatic void add_row(longint sec, bit typed, date_t want);
    stim_row_t r;
    r.sec   = sec[IN_W-1:0];
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  // Mostly in-range timestamps, with day edges, both ends of the range,
  // arbitrary 40-bit words and values just outside the range mixed in.
  function automatic logic signed [IN_W-1:0] pick_epoch_second();
    longint unsigned r;
    longint          dd, s;
    int              k;
    k = $urandom_range(0, 99);
    r = {$urandom, $urandom};
    if (k < 55) begin
      s = longint'(r % 64'd253402300800);
    end else if (k < 70) begin
      dd = $urandom_range(0, int'(LAST_DAY));
      case ($urandom_range(0, 2))
        0:       s = dd * 86400;
        1:       s = dd * 86400 + 86399;
        default: s = dd * 86400 + $urandom_range(0, 86399);
      endcase
    end else if (k < 74) begin
      s = $urandom_range(0, 200000);
    end else if (k < 78) begin
      s = LAST_SECOND - $urandom_range(0, 200000);
    end else if (k < 90) begin
      s = longint'(r);
    end else if (k < 95) begin
      s = -longint'($urandom_range(1, 100000));
    end else begin
      s = LAST_SECOND + 1 + $urandom_range(0, 1000000);
    end
    return s[IN_W-1:0];
  endfunction

  function automatic void check_field(string name, logic signed [IN_W-1:0] sec,
                                      logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: epoch second %0d: %s expected %0d, got %0d",
                 $realtime, sec, name, want, got);
    end
  endfunction

  task automatic offer_epoch(input logic signed [IN_W-1:0] sec, input date_t want,
                             input int gap);
    @(negedge clk);
    if (gap > 0) begin
      epoch_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    epoch_valid  <= 1'b1;
    epoch_second <= sec;
    epoch_want   <= want;
    do @(posedge clk); while (epoch_stall);
  endtask

  // Both channels are watched at the rising edge, after the falling-edge drive.
  always @(posedge clk) begin : watch_channels
    conversion_t exp_c;
    conversion_t taken;
    if (!rst) begin
      if (epoch_valid && epoch_stall) held_inputs++;
      if (epoch_valid && !epoch_stall) begin
        taken.sec  = epoch_second;
        taken.want = epoch_want;
        pending_dates.push_back(taken);
        n_taken++;
        if (epoch_want.valid_res) n_in_range++;
      end
      if (date_valid && !date_stall) begin
        n_checked++;
        if (pending_dates.size() == 0) begin
          unexpected++;
          if (unexpected + mismatches <= MAX_REPORTS)
            $display("%0t: result with no item outstanding", $realtime);
        end else begin
          exp_c = pending_dates.pop_front();
          check_field("valid_res", exp_c.sec, 16'(exp_c.want.valid_res), 16'(valid_res));
          check_field("year",      exp_c.sec, 16'(exp_c.want.year),      16'(year));
          check_field("month",     exp_c.sec, 16'(exp_c.want.month),     16'(month));
          check_field("day",       exp_c.sec, 16'(exp_c.want.day),       16'(day));
          check_field("hour",      exp_c.sec, 16'(exp_c.want.hour),      16'(hour));
          check_field("minute",    exp_c.sec, 16'(exp_c.want.minute),    16'(minute));
          check_field("second",    exp_c.sec, 16'(exp_c.want.second),    16'(second));
        end
      end
    end
  end

  // Any stretch this long without an item moving on either side is a hang.
  always @(posedge clk) begin
    if ((epoch_valid && !epoch_stall) || (date_valid && !date_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: waits a random number of cycles before each item, none in quiet blocks,
  // and once holds off for a long stretch so the pipeline fills and stalls the input.
  initial begin : receiver
    int n;
    date_stall = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      n = quiet_rx ? 0 : $urandom_range(0, 11);
      if (squeeze_req) begin
        n = HOLD_CYCLES;
        squeeze_req = 1'b0;
      end
      @(negedge clk);
      if (n > 0) begin
        date_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      date_stall <= 1'b0;
      do @(posedge clk); while (!date_valid);
    end
  end

  initial begin : stimulus
    date_t want;
    logic signed [IN_W-1:0] sec;
    rst          = 1'b1;
    epoch_valid  = 1'b0;
    epoch_second = '0;
    epoch_want   = NO_DATE;

    add_row(64'sd0,            1'b1, civil(1970, 1, 1, 0, 0, 0));
    add_row(64'sd59,           1'b1, civil(1970, 1, 1, 0, 0, 59));
    add_row(64'sd3599,         1'b1, civil(1970, 1, 1, 0, 59, 59));
    add_row(64'sd3600,         1'b1, civil(1970, 1, 1, 1, 0, 0));
    add_row(64'sd86399,        1'b1, civil(1970, 1, 1, 23, 59, 59));
    add_row(64'sd86400,        1'b1, civil(1970, 1, 2, 0, 0, 0));
    add_row(LAST_SECOND,       1'b1, civil(9999, 12, 31, 23, 59, 59));
    add_row(LAST_SECOND + 1,   1'b1, NO_DATE);
    add_row(-64'sd1,           1'b1, NO_DATE);
    add_row(-64'sd549755813888, 1'b1, NO_DATE);
    add_row(64'sd549755813887, 1'b1, NO_DATE);
    // Year ends, leap days, century rules and the 32-bit boundaries.
    add_row(64'sd31535999,     1'b0, NO_DATE);
    add_row(64'sd31536000,     1'b0, NO_DATE);
    add_row(64'sd68169600,     1'b0, NO_DATE);
    add_row(64'sd946684799,    1'b0, NO_DATE);
    add_row(64'sd951782400,    1'b0, NO_DATE);
    add_row(64'sd951868800,    1'b0, NO_DATE);
    add_row(64'sd2147483647,   1'b0, NO_DATE);
    add_row(64'sd2147483648,   1'b0, NO_DATE);
    add_row(64'sd4107456000,   1'b0, NO_DATE);
    add_row(64'sd4107542400,   1'b0, NO_DATE);
    add_row(64'sd13574563200,  1'b0, NO_DATE);
    add_row(64'sd68719476735,  1'b0, NO_DATE);
    add_row(64'sd253402214400, 1'b0, NO_DATE);
    add_row(64'sd274877906944, 1'b0, NO_DATE);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      want = dir_rows[i].typed ? dir_rows[i].want : civil_from_epoch(dir_rows[i].sec);
      offer_epoch(dir_rows[i].sec, want, $urandom_range(0, 11));
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % BLOCK_ITEMS == 0) begin
        quiet_tx = ($urandom_range(0, 3) == 0);
        quiet_rx = ($urandom_range(0, 3) == 0);
        // Keep the input busy while the receiver holds off.
        if (i == SQUEEZE_AT) begin
          quiet_tx    = 1'b1;
          squeeze_req = 1'b1;
        end
      end
      sec = pick_epoch_second();
      offer_epoch(sec, civil_from_epoch(sec), quiet_tx ? 0 : $urandom_range(0, 11));
    end
    @(negedge clk);
    epoch_valid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("Converted %0d timestamps, %0d in range and %0d rejected; %0d results checked.",
             n_taken, n_in_range, n_taken - n_in_range, n_checked);
    $display("The input was held off for %0d cycles by output backpressure.", held_inputs);
    if (mismatches == 0 && unexpected == 0 && pending_dates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d field mismatches, %0d unexpected results", mismatches, unexpected);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
